// ===== hw/rtl/jddm_pkg.sv =====
// ---------------------------------------------------------------------------
// Joystick mixer package
// Shared constants, codes, queue entry and sequencer types, and the
// arctangent table of the angle unit.
// ---------------------------------------------------------------------------
package jddm_pkg;

   // Default configuration of the top level.
   localparam int DEF_AXIS_FULL_SCALE = 32767;
   localparam int DEF_ANGLE_STEPS     = 16;

   // Arithmetic limits.
   localparam int VEL_LIMIT     = 25600;
   localparam int THROTTLE_GAIN = 12800;
   localparam int DIV_NUM_W     = 30;

   // Axis codes of an incoming request.
   localparam logic [2:0] MODE_HAT_UD   = 3'd0;
   localparam logic [2:0] MODE_HAT_LR   = 3'd1;
   localparam logic [2:0] MODE_THROTTLE = 3'd2;
   localparam logic [2:0] MODE_STICK_Y  = 3'd3;
   localparam logic [2:0] MODE_STICK_X  = 3'd4;
   localparam logic [2:0] MODE_ROLL     = 3'd5;

   // Work kinds carried through the queue.
   typedef enum logic [2:0] {
      OP_HAT_UD,
      OP_HAT_LR,
      OP_THROTTLE,
      OP_STICK_Y,
      OP_STICK_X
   } op_type;

   // One queued job: the kind and its prepared operand.
   typedef struct packed {
      op_type                 op;
      logic [DIV_NUM_W-1:0]   data;
   } job_type;

   // Status of one divider lane.
   typedef struct packed {
      logic        done;
      logic [14:0] quotient;
   } div_result_type;

   // Back-end sequencer states.
   typedef enum logic [3:0] {
      BK_IDLE,
      BK_SPEED,
      BK_MIX,
      BK_CORDIC,
      BK_FACTOR,
      BK_PRODUCT,
      BK_SCALE,
      BK_DIVIDE,
      BK_OUT
   } back_state_type;

   // Arctangent of 2^-i in binary-angle units (65536 per turn).
   function automatic logic signed [17:0] atan_entry(input logic [4:0] idx);
      logic signed [17:0] val;
      case (idx)
         5'd0:    val = 18'sd8192;
         5'd1:    val = 18'sd4836;
         5'd2:    val = 18'sd2555;
         5'd3:    val = 18'sd1297;
         5'd4:    val = 18'sd651;
         5'd5:    val = 18'sd326;
         5'd6:    val = 18'sd163;
         5'd7:    val = 18'sd81;
         5'd8:    val = 18'sd41;
         5'd9:    val = 18'sd20;
         5'd10:   val = 18'sd10;
         5'd11:   val = 18'sd5;
         5'd12:   val = 18'sd3;
         5'd13:   val = 18'sd1;
         5'd14:   val = 18'sd1;
         default: val = 18'sd0;
      endcase
      return val;
   endfunction

endpackage

// ===== hw/rtl/jddm_queue.sv =====
// ---------------------------------------------------------------------------
// Joystick mixer job queue
// Two-entry first-in first-out buffer between the front and back ends.
// ---------------------------------------------------------------------------
module jddm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  jddm_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output jddm_pkg::job_type head_job
);
   import jddm_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign full     = count_ff[1];
   assign valid    = count_ff != 2'd0;
   assign head_job = entry_ff[rd_ptr_ff];

endmodule

// ===== hw/rtl/jddm_front.sv =====
// ---------------------------------------------------------------------------
// Joystick mixer front end
// Accepts requests, decodes the axis code and prepares the operand of each
// job: hat direction, saturated stick position or throttle numerator.
// ---------------------------------------------------------------------------
module jddm_front #(
   parameter int AXIS_FULL_SCALE = jddm_pkg::DEF_AXIS_FULL_SCALE
) (
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic signed [15:0] req_axis_value,
   input  logic               queue_full,
   output logic               push,
   output jddm_pkg::job_type  push_job
);
   import jddm_pkg::*;

   localparam logic signed [17:0] FS_S = 18'(AXIS_FULL_SCALE);
   localparam logic [DIV_NUM_W-1:0] HALF_FS = DIV_NUM_W'(AXIS_FULL_SCALE / 2);

   logic               accept;
   logic               known;
   logic signed [17:0] value_s;
   logic signed [17:0] neg_s;
   logic signed [17:0] throttle_d;
   logic [15:0]        throttle_u;
   logic [DIV_NUM_W-1:0] throttle_num;
   logic [15:0]        stick_x;
   logic [15:0]        stick_y;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // Operand preparation.
   always_comb begin
      value_s    = 18'(req_axis_value);
      neg_s      = -value_s;
      throttle_d = FS_S - value_s;
      throttle_u = throttle_d[17] ? 16'd0 : throttle_d[15:0];
      throttle_num = DIV_NUM_W'(THROTTLE_GAIN) * DIV_NUM_W'(throttle_u) + HALF_FS;
      if (value_s > FS_S) begin
         stick_x = FS_S[15:0];
      end else if (value_s < -FS_S) begin
         stick_x = 16'(-FS_S);
      end else begin
         stick_x = value_s[15:0];
      end
      if (neg_s > FS_S) begin
         stick_y = FS_S[15:0];
      end else if (neg_s < -FS_S) begin
         stick_y = 16'(-FS_S);
      end else begin
         stick_y = neg_s[15:0];
      end
   end

   // Axis code decoder.
   always_comb begin
      known         = 1'b1;
      push_job.op   = OP_HAT_UD;
      push_job.data = '0;
      unique case (req_mode)
         MODE_HAT_UD, MODE_HAT_LR: begin
            push_job.op   = (req_mode == MODE_HAT_UD) ? OP_HAT_UD : OP_HAT_LR;
            push_job.data = {28'd0, req_axis_value[15],
                             (req_axis_value != 16'sd0) && !req_axis_value[15]};
         end
         MODE_THROTTLE: begin
            push_job.op   = OP_THROTTLE;
            push_job.data = throttle_num;
         end
         MODE_STICK_Y: begin
            push_job.op   = OP_STICK_Y;
            push_job.data = {14'd0, stick_y};
         end
         MODE_STICK_X: begin
            push_job.op   = OP_STICK_X;
            push_job.data = {14'd0, stick_x};
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   // Roll and unknown codes are taken and dropped.
   assign push = accept && known;

endmodule

// ===== hw/rtl/jddm_div.sv =====
// ---------------------------------------------------------------------------
// Joystick mixer divider lane
// Division by the axis full scale through a registered reciprocal
// multiplication, with the quotient saturated to the velocity limit.
// ---------------------------------------------------------------------------
module jddm_div #(
   parameter int AXIS_FULL_SCALE = jddm_pkg::DEF_AXIS_FULL_SCALE
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [jddm_pkg::DIV_NUM_W-1:0] numer,
   output jddm_pkg::div_result_type     result
);
   import jddm_pkg::*;

   // The rounded-up reciprocal is exact for every numerator below 2^DIV_NUM_W.
   localparam int     RECIP_SHIFT = DIV_NUM_W + $clog2(AXIS_FULL_SCALE);
   localparam longint RECIP       = ((longint'(1) <<< RECIP_SHIFT)
                                     + longint'(AXIS_FULL_SCALE) - 1)
                                    / longint'(AXIS_FULL_SCALE);
   localparam int     RECIP_W     = DIV_NUM_W + 1;
   localparam int     PROD_W      = DIV_NUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

   logic                 stage_ff, stage_in;
   logic                 done_ff, done_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [PROD_W-1:0]    quot_full;

   // Operand capture, then the reciprocal product.
   always_comb begin
      num_in   = start ? numer : num_ff;
      stage_in = start;
      done_in  = stage_ff;
      prod_in  = num_ff * RECIP_V;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
      num_ff  <= num_in;
      prod_ff <= prod_in;
   end

   // Saturated quotient.
   assign quot_full       = prod_ff >> RECIP_SHIFT;
   assign result.done     = done_ff;
   assign result.quotient = (quot_full > PROD_W'(VEL_LIMIT)) ? 15'(VEL_LIMIT)
                                                            : quot_full[14:0];

endmodule

// ===== hw/rtl/jddm_back.sv =====
// ---------------------------------------------------------------------------
// Joystick mixer back end
// Holds the throttle and stick state and carries out each job: hat result,
// throttle division, CORDIC angle, wheel factors, scaling and output.
// ---------------------------------------------------------------------------
module jddm_back #(
   parameter int AXIS_FULL_SCALE = jddm_pkg::DEF_AXIS_FULL_SCALE,
   parameter int ANGLE_STEPS     = jddm_pkg::DEF_ANGLE_STEPS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  jddm_pkg::job_type  job,
   output logic               job_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_left_velocity,
   output logic signed [15:0] rsp_right_velocity
);
   import jddm_pkg::*;

   localparam logic [4:0]  LAST_STEP = 5'(ANGLE_STEPS - 1);
   localparam logic [44:0] ROUND_ADD = 45'(AXIS_FULL_SCALE) << 12;

   back_state_type state_ff, state_in;

   logic [14:0]        speed_ff;
   logic signed [15:0] x_ff, y_ff;
   logic signed [25:0] cx_ff, cy_ff;
   logic signed [17:0] z_ff;
   logic [4:0]         step_ff;
   logic [29:0]        p_ff;
   logic [13:0]        lmag_ff, rmag_ff;
   logic               lneg_ff, rneg_ff;
   logic [43:0]        lprod_ff, rprod_ff;
   logic signed [15:0] res_l_ff, res_r_ff;
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_left_ff, rsp_right_ff;

   logic               out_free;
   logic               div_start_speed, div_start_scale;
   logic [DIV_NUM_W-1:0] div_num_l, div_num_r;
   div_result_type     div_l, div_r;
   logic               mix_centre;
   logic               last_step;
   logic [14:0]        mag;
   logic signed [25:0] sx, sy;
   logic signed [25:0] init_x, init_y;
   logic signed [16:0] angle;
   logic signed [15:0] lf, rf;
   logic signed [15:0] speed_s;

   // Status decode.
   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      mix_centre = (x_ff == 16'sd0) && (y_ff == 16'sd0);
      last_step  = step_ff == LAST_STEP;
      mag        = ((x_ff < 0 ? -x_ff : x_ff) > (y_ff < 0 ? -y_ff : y_ff))
                   ? 15'(x_ff < 0 ? -x_ff : x_ff) : 15'(y_ff < 0 ? -y_ff : y_ff);
      speed_s    = {1'b0, speed_ff};
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               unique case (job.op)
                  OP_HAT_UD, OP_HAT_LR: state_in = BK_OUT;
                  OP_THROTTLE:          state_in = BK_SPEED;
                  default:              state_in = BK_MIX;
               endcase
            end
         end
         BK_SPEED:   if (div_l.done) state_in = BK_MIX;
         BK_MIX:     state_in = mix_centre ? BK_OUT : BK_CORDIC;
         BK_CORDIC:  if (last_step) state_in = BK_FACTOR;
         BK_FACTOR:  state_in = BK_PRODUCT;
         BK_PRODUCT: state_in = BK_SCALE;
         BK_SCALE:   state_in = BK_DIVIDE;
         BK_DIVIDE:  if (div_l.done) state_in = BK_OUT;
         BK_OUT:     if (out_free) state_in = BK_IDLE;
         default:    state_in = BK_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      job_pop         = (state_ff == BK_IDLE) && job_valid;
      div_start_speed = job_pop && (job.op == OP_THROTTLE);
      div_start_scale = state_ff == BK_SCALE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // CORDIC step and angle to factor mapping.
   always_comb begin
      sx     = cx_ff >>> step_ff;
      sy     = cy_ff >>> step_ff;
      init_x = 26'(x_ff) <<< 8;
      init_y = 26'(y_ff) <<< 8;
      if (z_ff > 18'sd32768) begin
         angle = 17'sd32767 + 17'sd1;
      end else if (z_ff < -18'sd32768) begin
         angle = -17'sd32768;
      end else begin
         angle = z_ff[16:0];
      end
      if (angle > 17'sd16384) begin
         rf = 16'(17'sd24576 - angle);
         lf = 16'sd8192;
      end else if (angle > 17'sd0) begin
         rf = 16'sd8192;
         lf = 16'(angle - 17'sd8192);
      end else if (angle < -17'sd16384) begin
         rf = -16'sd8192;
         lf = 16'(-(angle + 17'sd24576));
      end else begin
         rf = 16'(angle + 17'sd8192);
         lf = -16'sd8192;
      end
      div_num_l = div_start_speed ? job.data : 30'((lprod_ff + ROUND_ADD) >> 13);
      div_num_r = 30'((rprod_ff + ROUND_ADD) >> 13);
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= 15'd0;
         x_ff     <= 16'sd0;
         y_ff     <= 16'sd0;
      end else begin
         unique case (state_ff)
            BK_IDLE: begin
               if (job_valid) begin
                  case (job.op)
                     OP_HAT_UD: begin
                        res_l_ff <= job.data[0] ? speed_s : job.data[1] ? -speed_s : 16'sd0;
                        res_r_ff <= job.data[0] ? speed_s : job.data[1] ? -speed_s : 16'sd0;
                     end
                     OP_HAT_LR: begin
                        res_l_ff <= job.data[0] ? speed_s : job.data[1] ? -speed_s : 16'sd0;
                        res_r_ff <= job.data[0] ? -speed_s : job.data[1] ? speed_s : 16'sd0;
                     end
                     OP_STICK_Y: y_ff <= job.data[15:0];
                     OP_STICK_X: x_ff <= job.data[15:0];
                     default: ;
                  endcase
               end
            end
            BK_SPEED: begin
               if (div_l.done) begin
                  speed_ff <= div_l.quotient;
               end
            end
            BK_MIX: begin
               res_l_ff <= 16'sd0;
               res_r_ff <= 16'sd0;
               p_ff     <= 30'(mag) * 30'(speed_ff);
               step_ff  <= 5'd0;
               if (x_ff < 0) begin
                  cx_ff <= -init_x;
                  cy_ff <= -init_y;
                  z_ff  <= (init_y >= 0) ? 18'sd32768 : -18'sd32768;
               end else begin
                  cx_ff <= init_x;
                  cy_ff <= init_y;
                  z_ff  <= 18'sd0;
               end
            end
            BK_CORDIC: begin
               step_ff <= step_ff + 5'd1;
               if (cy_ff > 0) begin
                  cx_ff <= cx_ff + sy;
                  cy_ff <= cy_ff - sx;
                  z_ff  <= z_ff + atan_entry(step_ff);
               end else begin
                  cx_ff <= cx_ff - sy;
                  cy_ff <= cy_ff + sx;
                  z_ff  <= z_ff - atan_entry(step_ff);
               end
            end
            BK_FACTOR: begin
               lneg_ff <= lf < 0;
               rneg_ff <= rf < 0;
               lmag_ff <= 14'(lf < 0 ? -lf : lf);
               rmag_ff <= 14'(rf < 0 ? -rf : rf);
            end
            BK_PRODUCT: begin
               lprod_ff <= 44'(p_ff) * 44'(lmag_ff);
               rprod_ff <= 44'(p_ff) * 44'(rmag_ff);
            end
            BK_DIVIDE: begin
               if (div_l.done) begin
                  res_l_ff <= lneg_ff ? 16'(div_l.quotient) : -16'(div_l.quotient);
                  res_r_ff <= rneg_ff ? 16'(div_r.quotient) : -16'(div_r.quotient);
               end
            end
            default: ;
         endcase
      end
   end

   // Output register towards the result channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == BK_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == BK_OUT && out_free) begin
         rsp_left_ff  <= res_l_ff;
         rsp_right_ff <= res_r_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_left_velocity  = rsp_left_ff;
   assign rsp_right_velocity = rsp_right_ff;

   // Divider lanes: the left lane also serves the throttle.
   jddm_div #(.AXIS_FULL_SCALE(AXIS_FULL_SCALE)) u_div_l (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start_speed || div_start_scale),
      .numer  (div_num_l),
      .result (div_l)
   );

   jddm_div #(.AXIS_FULL_SCALE(AXIS_FULL_SCALE)) u_div_r (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start_scale),
      .numer  (div_num_r),
      .result (div_r)
   );

`ifndef ASSERT_OFF
   // Both lanes of a scaling division finish together.
   a_lanes_together: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIVIDE && div_l.done) |-> div_r.done)
      else $error("divider lanes out of step");

   // The throttle level never leaves its range.
   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      speed_ff <= 15'(VEL_LIMIT))
      else $error("speed level out of range");

   // Results stay within the velocity limit.
   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_left_ff <= 16'sd25600 && rsp_left_ff >= -16'sd25600 &&
                        rsp_right_ff <= 16'sd25600 && rsp_right_ff >= -16'sd25600))
      else $error("velocity out of range");

   // A finished job is presented and the sequencer returns to idle.
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_OUT && out_free) |=> (rsp_valid_ff && state_ff == BK_IDLE))
      else $error("result not presented");
`endif

endmodule

// ===== hw/rtl/joystick_differential_drive_mixer_core.sv =====
// ---------------------------------------------------------------------------
// Joystick differential-drive mixer
// Turns joystick axis requests into left and right wheel velocities.
// ---------------------------------------------------------------------------
// Each request carries an axis code and a signed position. The front end
// takes a request and places it in a two-entry queue, so it keeps accepting
// while the back end works, until the queue is full. From idle, a hat request
// goes straight to output, and a centred stick through set-up and output.
// A stick request passes through queueing, set-up, ANGLE_STEPS steps of the
// shared CORDIC iteration, factor, product, scaling and the division by the
// full scale by reciprocal multiplication, with both wheels divided in
// parallel, and then output. A throttle request first passes through the
// division that sets the speed level. Roll and unknown codes are taken and
// dropped.
module joystick_differential_drive_mixer_core #(
   parameter int AXIS_FULL_SCALE = jddm_pkg::DEF_AXIS_FULL_SCALE,
   parameter int ANGLE_STEPS     = jddm_pkg::DEF_ANGLE_STEPS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic signed [15:0] req_axis_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_left_velocity,
   output logic signed [15:0] rsp_right_velocity
);
   import jddm_pkg::*;

   logic    push, queue_full, job_valid, job_pop;
   job_type push_job, head_job;

   // Request decoding.
   jddm_front #(.AXIS_FULL_SCALE(AXIS_FULL_SCALE)) u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_axis_value (req_axis_value),
      .queue_full     (queue_full),
      .push           (push),
      .push_job       (push_job)
   );

   // Job queue.
   jddm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (job_pop),
      .valid    (job_valid),
      .head_job (head_job)
   );

   // Mixing engine.
   jddm_back #(
      .AXIS_FULL_SCALE (AXIS_FULL_SCALE),
      .ANGLE_STEPS     (ANGLE_STEPS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .job_valid          (job_valid),
      .job                (head_job),
      .job_pop            (job_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_left_velocity  (rsp_left_velocity),
      .rsp_right_velocity (rsp_right_velocity)
   );

endmodule
